// File: rtl/tdt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tdt_pkg
// Shared types and constants of the touch d-pad tracker.
// ----------------------------------------------------------------------------
package tdt_pkg;

    localparam int CfgIdxW = 3;
    localparam int CfgDataW = 12;
    localparam logic [CfgIdxW-1:0] REG_VP_W = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_VP_H = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_SCR_W = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_SCR_H = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_RENDER = 3'd4;

    localparam logic [3:0] ACT_NONE = 4'd0;
    localparam logic [3:0] ACT_UP = 4'd1;
    localparam logic [3:0] ACT_UPRIGHT = 4'd2;
    localparam logic [3:0] ACT_RIGHT = 4'd3;
    localparam logic [3:0] ACT_DOWNRIGHT = 4'd4;
    localparam logic [3:0] ACT_DOWN = 4'd5;
    localparam logic [3:0] ACT_DOWNLEFT = 4'd6;
    localparam logic [3:0] ACT_LEFT = 4'd7;
    localparam logic [3:0] ACT_UPLEFT = 4'd8;
    localparam logic [3:0] ACT_FIRE = 4'd9;

    typedef struct packed {
        logic        op;
        logic [15:0] finger_id;
        logic [31:0] stamp;
        logic [3:0]  action;
    } tdt_cmd_t;

    typedef enum logic [1:0] {
        GEO_IDLE,
        GEO_SQ,
        GEO_QUART,
        GEO_DONE
    } geo_state_t;

    function automatic logic [4:0] action_events(input logic [3:0] a);
        logic [4:0] e;
        begin
            unique case (a)
                ACT_UP:        e = 5'h01;
                ACT_UPRIGHT:   e = 5'h09;
                ACT_RIGHT:     e = 5'h08;
                ACT_DOWNRIGHT: e = 5'h0A;
                ACT_DOWN:      e = 5'h02;
                ACT_DOWNLEFT:  e = 5'h06;
                ACT_LEFT:      e = 5'h04;
                ACT_UPLEFT:    e = 5'h05;
                ACT_FIRE:      e = 5'h10;
                default:       e = 5'h00;
            endcase
            return e;
        end
    endfunction

endpackage
`default_nettype wire

// File: rtl/touch_dpad_tracker_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// touch_dpad_tracker_top
// Virtual touch d-pad: classifies touch points and tracks held fingers.
// ----------------------------------------------------------------------------
// Channel   Direction  Content
// s_axis    in         op (tuser); finger_id, x_pos, y_pos, stamp (tdata)
// m_axis    out        action, held_events, pad_hit, release_unknown (tdata)
// cfg       in         wr_en, wr_index, wr_data register writes
//
// A result is registered in the table stage after its item has passed the
// front geometry sequencer steps (scale, square, quartic, hand-off).
// The next item is accepted only after the previous command is handed off.
// Reset clears the finger table and all handshake state at once.
// A stalled result holds the table stage, and the front then waits on it.
// ----------------------------------------------------------------------------
module touch_dpad_tracker_top #(
    parameter int TOUCH_SLOTS = 5,
    parameter int PAD_HALF = 40,
    parameter int FIRE_SIZE = 40
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    // finger_id[15:0], x_pos[32:16], y_pos[49:33], stamp[81:50]
    input  wire logic [87:0]                  s_axis_tdata,
    // op[0]
    input  wire logic                         s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    // action[3:0], held_events[8:4], pad_hit[9], release_unknown[10]
    output logic [15:0]                       m_axis_tdata,
    input  wire logic                         wr_en,
    input  wire logic [tdt_pkg::CfgIdxW-1:0]  wr_index,
    input  wire logic [tdt_pkg::CfgDataW-1:0] wr_data
);
    import tdt_pkg::*;

    logic [11:0] vp_w_reg, vp_h_reg, scr_w_reg, scr_h_reg;
    logic        render_reg;
    logic        cmd_valid, cmd_ready;
    tdt_cmd_t    cmd;
    logic [3:0]  action;
    logic [4:0]  held_events;
    logic        pad_hit, release_unknown;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vp_w_reg <= 12'd320;
            vp_h_reg <= 12'd200;
            scr_w_reg <= 12'd320;
            scr_h_reg <= 12'd200;
            render_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_VP_W:   vp_w_reg <= wr_data;
                REG_VP_H:   vp_h_reg <= wr_data;
                REG_SCR_W:  scr_w_reg <= wr_data;
                REG_SCR_H:  scr_h_reg <= wr_data;
                REG_RENDER: render_reg <= wr_data[0];
                default:    render_reg <= render_reg;
            endcase
        end
    end

    tdt_geom #(.PAD_HALF(PAD_HALF), .FIRE_SIZE(FIRE_SIZE)) u_geom (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .op(s_axis_tuser), .finger_id(s_axis_tdata[15:0]),
        .x_pos(s_axis_tdata[32:16]), .y_pos(s_axis_tdata[49:33]),
        .stamp(s_axis_tdata[81:50]),
        .vp_w(vp_w_reg), .vp_h(vp_h_reg), .scr_w(scr_w_reg), .scr_h(scr_h_reg),
        .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd)
    );

    tdt_table #(.TOUCH_SLOTS(TOUCH_SLOTS)) u_table (
        .clk(clk), .rst_n(rst_n),
        .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
        .render_en(render_reg),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .action(action), .held_events(held_events),
        .pad_hit(pad_hit), .release_unknown(release_unknown)
    );

    assign m_axis_tdata = {5'd0, release_unknown, pad_hit, held_events, action};
endmodule
`default_nettype wire

// File: rtl/tdt_geom.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tdt_geom
// Front part: scales the touch point, tests the fire box and pad window and
// picks the pad sector over a few registered steps, then queues a command.
// ----------------------------------------------------------------------------
module tdt_geom #(
    parameter int PAD_HALF = 40,
    parameter int FIRE_SIZE = 40
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic                 op,
    input  wire logic [15:0]          finger_id,
    input  wire logic [16:0]          x_pos,
    input  wire logic [16:0]          y_pos,
    input  wire logic [31:0]          stamp,
    input  wire logic [11:0]          vp_w,
    input  wire logic [11:0]          vp_h,
    input  wire logic [11:0]          scr_w,
    input  wire logic [11:0]          scr_h,
    output logic                      cmd_valid,
    input  wire logic                 cmd_ready,
    output tdt_pkg::tdt_cmd_t         cmd
);
    import tdt_pkg::*;

    geo_state_t state_reg, state_next;
    logic        op_reg;
    logic [15:0] id_reg;
    logic [31:0] stamp_reg;
    logic signed [14:0] dx_reg, dy_reg;
    logic        inwin_reg, fire_reg;
    logic [27:0] xx_reg, yy_reg;
    logic signed [58:0] qv_reg, qh_reg;

    logic [28:0] mx, my;
    logic signed [14:0] px, py, fx, fy, cy;
    logic signed [14:0] padlo, padhi;
    logic        inwin, fire;
    logic [55:0] x4, y4, x2y2;
    logic signed [58:0] qv, qh;
    logic        steep, flat;
    logic        s0, s1, s2, s3;
    logic [3:0]  act;
    logic        xneg, yneg, xpos, ypos;

    assign mx = x_pos * vp_w;
    assign my = y_pos * vp_h;
    assign px = 15'(mx[28:16]);
    assign py = 15'(my[28:16]);
    assign fx = $signed({3'b0, scr_w}) - 15'(FIRE_SIZE + 18);
    assign fy = $signed({3'b0, scr_h}) - 15'(FIRE_SIZE + 28);
    assign cy = $signed({3'b0, scr_h}) - 15'(PAD_HALF + 10);
    assign padlo = 15'sd10;
    assign padhi = 15'(2 * PAD_HALF + 10);

    always_comb
    begin
        fire = (px >= fx) && (px < fx + 15'(FIRE_SIZE))
            && (py >= fy) && (py < fy + 15'(FIRE_SIZE));
        inwin = (px >= padlo) && (px < padhi)
            && (py >= cy - 15'(PAD_HALF)) && (py < cy + 15'(PAD_HALF));
    end

    assign x4 = xx_reg * xx_reg;
    assign y4 = yy_reg * yy_reg;
    assign x2y2 = xx_reg * yy_reg;
    assign qv = $signed({3'b0, y4}) - ($signed({3'b0, x2y2}) <<< 3)
        + ($signed({3'b0, x4}) <<< 3);
    assign qh = $signed({3'b0, x4}) - ($signed({3'b0, x2y2}) <<< 3)
        + ($signed({3'b0, y4}) <<< 3);

    always_comb
    begin
        steep = yy_reg >= (xx_reg << 1);
        flat = xx_reg >= (yy_reg << 1);
        xneg = dx_reg < 0;
        yneg = dy_reg < 0;
        xpos = dx_reg > 0;
        ypos = dy_reg > 0;
        if (xneg)
            s0 = yneg ? (steep ? qv_reg >= 0 : 1'b0) : 1'b0;
        else
            s0 = !ypos ? 1'b1 : (steep ? qv_reg <= 0 : 1'b1);
        if (xneg)
            s1 = !ypos ? 1'b1 : (steep ? qv_reg <= 0 : 1'b1);
        else
            s1 = ypos ? 1'b0 : (steep ? qv_reg >= 0 : 1'b0);
        if (xneg)
            s2 = !ypos ? 1'b1 : (flat ? qh_reg >= 0 : 1'b0);
        else
            s2 = ypos ? 1'b0 : (flat ? qh_reg <= 0 : 1'b1);
        if (xneg)
            s3 = yneg ? (flat ? qh_reg <= 0 : 1'b1) : 1'b0;
        else
            s3 = !ypos ? 1'b1 : (flat ? qh_reg >= 0 : 1'b0);
        if (fire_reg)
            act = ACT_FIRE;
        else if (!inwin_reg)
            act = ACT_NONE;
        else if (s1)
            act = s3 ? (s0 ? ACT_UP : ACT_UPLEFT) : (s2 ? ACT_LEFT : ACT_DOWNLEFT);
        else
            act = s3 ? (s2 ? ACT_UPRIGHT : ACT_RIGHT) : (s0 ? ACT_DOWNRIGHT : ACT_DOWN);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            GEO_IDLE:  if (in_valid) state_next = GEO_SQ;
            GEO_SQ:    state_next = GEO_QUART;
            GEO_QUART: state_next = GEO_DONE;
            GEO_DONE:  if (cmd_ready) state_next = GEO_IDLE;
            default:   state_next = GEO_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = (state_reg == GEO_IDLE);
        cmd_valid = (state_reg == GEO_DONE);
        cmd.op = op_reg;
        cmd.finger_id = id_reg;
        cmd.stamp = stamp_reg;
        cmd.action = op_reg ? ACT_NONE : act;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= GEO_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            GEO_IDLE:
            begin
                op_reg <= op;
                id_reg <= finger_id;
                stamp_reg <= stamp;
                fire_reg <= fire;
                inwin_reg <= inwin;
                dx_reg <= px - 15'(PAD_HALF + 10);
                dy_reg <= py - cy;
            end
            GEO_SQ:
            begin
                xx_reg <= 28'(dx_reg * dx_reg);
                yy_reg <= 28'(dy_reg * dy_reg);
            end
            GEO_QUART:
            begin
                qv_reg <= qv;
                qh_reg <= qh;
            end
            default:
            begin
            end
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_ready |=> cmd_valid && $stable(cmd))
        else $error("command changed while stalled");
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !cmd_valid)
        else $error("command too early");
    assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && cmd_valid))
        else $error("front overlap");
endmodule
`default_nettype wire

// File: rtl/tdt_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tdt_table
// Back part: finger table lookup, replacement, release and held event OR,
// with a registered result.
// ----------------------------------------------------------------------------
module tdt_table #(
    parameter int TOUCH_SLOTS = 5
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cmd_valid,
    output logic               cmd_ready,
    input  tdt_pkg::tdt_cmd_t  cmd,
    input  wire logic          render_en,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [3:0]         action,
    output logic [4:0]         held_events,
    output logic               pad_hit,
    output logic               release_unknown
);
    import tdt_pkg::*;

    localparam int SW = (TOUCH_SLOTS > 1) ? $clog2(TOUCH_SLOTS) : 1;

    logic [TOUCH_SLOTS-1:0] valid_reg, held_reg;
    logic [15:0] finger_reg [TOUCH_SLOTS];
    logic [31:0] stamp_reg [TOUCH_SLOTS];
    logic [4:0]  events_reg [TOUCH_SLOTS];
    logic [3:0]  action_reg [TOUCH_SLOTS];
    logic        out_valid_reg;
    logic [3:0]  o_act_reg;
    logic [4:0]  o_ev_reg;
    logic        o_hit_reg, o_unk_reg;

    logic        found;
    logic [SW-1:0] fidx, midx, sel;
    logic [31:0] mst;
    logic [TOUCH_SLOTS-1:0] vnext, hnext;
    logic [4:0]  enext [TOUCH_SLOTS];
    logic [4:0]  ev;
    logic        take;

    assign take = cmd_valid && cmd_ready;
    assign cmd_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        found = 1'b0;
        fidx = '0;
        for (int i = TOUCH_SLOTS - 1; i >= 0; i--)
            if (valid_reg[i] && finger_reg[i] == cmd.finger_id)
            begin
                found = 1'b1;
                fidx = SW'(i);
            end
        midx = '0;
        mst = stamp_reg[0];
        for (int i = 1; i < TOUCH_SLOTS; i++)
            if (stamp_reg[i] < mst)
            begin
                mst = stamp_reg[i];
                midx = SW'(i);
            end
        sel = found ? fidx : midx;
        vnext = valid_reg;
        hnext = held_reg;
        for (int i = 0; i < TOUCH_SLOTS; i++)
            enext[i] = events_reg[i];
        if (!cmd.op)
        begin
            vnext[sel] = 1'b1;
            hnext[sel] = 1'b1;
            enext[sel] = action_events(cmd.action);
        end
        else if (found)
        begin
            hnext[sel] = 1'b0;
            enext[sel] = 5'd0;
        end
        ev = '0;
        for (int i = 0; i < TOUCH_SLOTS; i++)
            if (vnext[i] && hnext[i])
                ev = ev | enext[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            held_reg <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < TOUCH_SLOTS; i++)
            begin
                finger_reg[i] <= '0;
                stamp_reg[i] <= '0;
                events_reg[i] <= '0;
                action_reg[i] <= '0;
            end
        end
        else
        begin
            if (take)
            begin
                valid_reg <= vnext;
                held_reg <= hnext;
                for (int i = 0; i < TOUCH_SLOTS; i++)
                    events_reg[i] <= enext[i];
                if (!cmd.op)
                begin
                    finger_reg[sel] <= cmd.finger_id;
                    stamp_reg[sel] <= cmd.stamp;
                    action_reg[sel] <= cmd.action;
                end
                else if (found)
                    action_reg[sel] <= ACT_NONE;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            o_act_reg <= cmd.action;
            o_ev_reg <= ev;
            o_hit_reg <= !cmd.op && render_en && (cmd.action != ACT_NONE);
            o_unk_reg <= cmd.op && !found;
        end
    end

    assign out_valid = out_valid_reg;
    assign action = o_act_reg;
    assign held_events = o_ev_reg;
    assign pad_hit = o_hit_reg;
    assign release_unknown = o_unk_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        take && cmd.op |=> !pad_hit && action == ACT_NONE)
        else $error("release result carries an action");
    assert property (@(posedge clk) disable iff (!rst_n)
        take && !cmd.op |=> !release_unknown)
        else $error("update flagged unknown");
    assert property (@(posedge clk) disable iff (!rst_n)
        (held_reg & ~valid_reg) == '0)
        else $error("held slot not valid");
endmodule
`default_nettype wire

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the touch d-pad tracker. Touch updates and releases
// are streamed in with bursty gaps while the result side stalls on its own
// pattern. A model of the geometry and the finger table predicts each result.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tdt_pkg::*;

    localparam int SLOTS = 5;
    localparam int HALF = 40;
    localparam int FIRE = 40;
    localparam int STALL_LIMIT = 2000;

    typedef struct packed {
        logic       unknown;
        logic       hit;
        logic [4:0] held;
        logic [3:0] action;
    } dpad_result_t;

    typedef struct {
        logic        op;
        logic [15:0] finger;
        logic [16:0] x;
        logic [16:0] y;
        logic [31:0] stamp;
        logic        fixed;
        logic [3:0]  act;
        logic [4:0]  held;
    } touch_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [87:0] s_axis_tdata = '0;
    logic s_axis_tuser = 1'b0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic wr_en = 1'b0;
    logic [CfgIdxW-1:0] wr_index = '0;
    logic [CfgDataW-1:0] wr_data = '0;

    logic [11:0] vp_w, vp_h, scr_w, scr_h;
    logic        render_on;
    logic        tab_valid [SLOTS];
    logic [15:0] tab_finger [SLOTS];
    logic [31:0] tab_stamp [SLOTS];
    logic [4:0]  tab_events [SLOTS];
    logic        tab_held [SLOTS];

    dpad_result_t pending_results [$];
    int errors = 0;
    int idle_cycles = 0;
    int sent = 0;
    int rx_count = 0;
    logic done = 1'b0;
    touch_row_t rows [$];

    always #5 clk = ~clk;

    touch_dpad_tracker_top DUT (.*);

    function automatic logic [4:0] events_of(input logic [3:0] a);
        case (a)
            ACT_UP:        return 5'h01;
            ACT_UPRIGHT:   return 5'h09;
            ACT_RIGHT:     return 5'h08;
            ACT_DOWNRIGHT: return 5'h0A;
            ACT_DOWN:      return 5'h02;
            ACT_DOWNLEFT:  return 5'h06;
            ACT_LEFT:      return 5'h04;
            ACT_UPLEFT:    return 5'h05;
            ACT_FIRE:      return 5'h10;
            default:       return 5'h00;
        endcase
    endfunction

    function automatic bit on_side(input int line, input longint x, input longint y);
        longint xx, yy, qv, qh;
        bit steep, flat;
        xx = x * x;
        yy = y * y;
        qv = yy * yy - 8 * xx * (yy - xx);
        qh = xx * xx - 8 * yy * (xx - yy);
        steep = yy >= 2 * xx;
        flat = xx >= 2 * yy;
        case (line)
            0: if (x < 0) return (y >= 0) ? 0 : (steep ? qv >= 0 : 0);
               else if (y <= 0) return 1;
               else return steep ? qv <= 0 : 1;
            1: if (x < 0) return (y <= 0) ? 1 : (steep ? qv <= 0 : 1);
               else if (y > 0) return 0;
               else return steep ? qv >= 0 : 0;
            2: if (x < 0) return (y <= 0) ? 1 : (flat ? qh >= 0 : 0);
               else if (y > 0) return 0;
               else return flat ? qh <= 0 : 1;
            default: if (x < 0) return (y >= 0) ? 0 : (flat ? qh <= 0 : 1);
               else if (y <= 0) return 1;
               else return flat ? qh >= 0 : 0;
        endcase
    endfunction

    function automatic logic [3:0] pad_action(input logic [16:0] xn, input logic [16:0] yn);
        longint x, y, fx, fy, cx, cy;
        x = longint'((64'(xn) * vp_w) >> 16);
        y = longint'((64'(yn) * vp_h) >> 16);
        fx = longint'(scr_w) - FIRE - 18;
        fy = longint'(scr_h) - FIRE - 28;
        cx = HALF + 10;
        cy = longint'(scr_h) - HALF - 10;
        if (x >= fx && x < fx + FIRE && y >= fy && y < fy + FIRE)
            return ACT_FIRE;
        if (x < cx - HALF || x >= cx + HALF || y < cy - HALF || y >= cy + HALF)
            return ACT_NONE;
        x -= cx;
        y -= cy;
        if (on_side(1, x, y))
        begin
            if (on_side(3, x, y))
                return on_side(0, x, y) ? ACT_UP : ACT_UPLEFT;
            return on_side(2, x, y) ? ACT_LEFT : ACT_DOWNLEFT;
        end
        if (on_side(3, x, y))
            return on_side(2, x, y) ? ACT_UPRIGHT : ACT_RIGHT;
        return on_side(0, x, y) ? ACT_DOWNRIGHT : ACT_DOWN;
    endfunction

    function automatic dpad_result_t track_touch(input touch_row_t r);
        dpad_result_t res;
        int s;
        res = '0;
        s = -1;
        for (int i = SLOTS - 1; i >= 0; i--)
            if (tab_valid[i] && tab_finger[i] == r.finger)
                s = i;
        if (r.op == 1'b0)
        begin
            if (s < 0)
            begin
                s = 0;
                for (int i = 1; i < SLOTS; i++)
                    if (tab_stamp[i] < tab_stamp[s])
                        s = i;
            end
            res.action = pad_action(r.x, r.y);
            tab_valid[s] = 1'b1;
            tab_finger[s] = r.finger;
            tab_stamp[s] = r.stamp;
            tab_held[s] = 1'b1;
            tab_events[s] = events_of(res.action);
            res.hit = render_on && res.action != ACT_NONE;
        end
        else if (s >= 0)
        begin
            tab_events[s] = '0;
            tab_held[s] = 1'b0;
        end
        else
            res.unknown = 1'b1;
        for (int i = 0; i < SLOTS; i++)
            if (tab_valid[i] && tab_held[i])
                res.held |= tab_events[i];
        return res;
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [11:0] val);
        @(posedge clk);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= val;
        @(posedge clk);
        wr_en <= 1'b0;
        case (idx)
            REG_VP_W:  vp_w = val;
            REG_VP_H:  vp_h = val;
            REG_SCR_W: scr_w = val;
            REG_SCR_H: scr_h = val;
            default:   render_on = val[0];
        endcase
    endtask

    task automatic send_rows();
        int burst;
        burst = 0;
        while (rows.size() > 0)
        begin
            if (burst == 0)
            begin
                burst = $urandom_range(1, 16);
                if ($urandom_range(0, 3) == 0)
                begin
                    s_axis_tvalid <= 1'b0;
                    repeat ($urandom_range(1, 12)) @(posedge clk);
                end
            end
            s_axis_tdata <= {6'b0, rows[0].stamp, rows[0].y, rows[0].x, rows[0].finger};
            s_axis_tuser <= rows[0].op;
            s_axis_tvalid <= 1'b1;
            do @(posedge clk); while (!s_axis_tready);
            begin
                touch_row_t r;
                dpad_result_t p;
                r = rows.pop_front();
                p = track_touch(r);
                if (r.fixed && (p.action != r.act || p.held != r.held))
                    report("table row", {p.action, p.held}, {r.act, r.held});
                pending_results.push_back(p);
                sent++;
            end
            burst--;
        end
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic drain();
        while (pending_results.size() > 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    function automatic touch_row_t mk(input logic op, input logic [15:0] f,
                                      input logic [16:0] x, input logic [16:0] y,
                                      input logic [31:0] st);
        touch_row_t r;
        r = '{op, f, x, y, st, 1'b0, 4'd0, 5'd0};
        return r;
    endfunction

    function automatic touch_row_t mk_fixed(input logic op, input logic [15:0] f,
                                            input logic [16:0] x, input logic [16:0] y,
                                            input logic [31:0] st, input logic [3:0] a,
                                            input logic [4:0] h);
        touch_row_t r;
        r = '{op, f, x, y, st, 1'b1, a, h};
        return r;
    endfunction

    // Pixel coordinates to normalized units for the current viewport.
    function automatic logic [16:0] nx(input int p, input logic [11:0] vp);
        return 17'((longint'(p) * 65536 + vp - 1) / vp);
    endfunction

    function automatic touch_row_t random_touch(input int pool);
        touch_row_t r;
        int px, py;
        r = mk($urandom_range(0, 4) == 0, 16'($urandom_range(0, pool)), '0, '0, $urandom());
        case ($urandom_range(0, 3))
            0: begin r.x = 17'($urandom_range(0, 65536)); r.y = 17'($urandom_range(0, 65536)); end
            1: begin r.x = 17'($urandom()); r.y = 17'($urandom()); end
            default:
            begin
                px = $urandom_range(0, 95) + 5;
                py = int'(scr_h) - 95 + $urandom_range(0, 90);
                if ($urandom_range(0, 3) == 0)
                begin
                    px = int'(scr_w) - 60 + $urandom_range(0, 45);
                    py = int'(scr_h) - 70 + $urandom_range(0, 45);
                end
                if (px < 0) px = 0;
                if (py < 0) py = 0;
                r.x = (px < int'(vp_w)) ? nx(px, vp_w) : 17'($urandom_range(0, 65536));
                r.y = (py < int'(vp_h)) ? nx(py, vp_h) : 17'($urandom_range(0, 65536));
            end
        endcase
        if ($urandom_range(0, 9) == 0) r.finger = 16'($urandom());
        return r;
    endfunction

    initial
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            tab_valid[i] = 0; tab_finger[i] = 0; tab_stamp[i] = 0;
            tab_events[i] = 0; tab_held[i] = 0;
        end
        vp_w = 320; vp_h = 200; scr_w = 320; scr_h = 200; render_on = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Pad center is (50,150); fire box spans x 262..301, y 132..171.
        rows.push_back(mk_fixed(1, 16'h0007, 0, 0, 0, ACT_NONE, 5'h00));
        rows.push_back(mk_fixed(0, 16'h0001, 0, 0, 1, ACT_NONE, 5'h00));
        rows.push_back(mk_fixed(0, 16'hFFFF, 17'h10000, 17'h10000, 32'hFFFFFFFF,
                                ACT_NONE, 5'h00));
        rows.push_back(mk_fixed(0, 16'h0002, nx(280, 320), nx(150, 200), 5,
                                ACT_FIRE, 5'h10));
        rows.push_back(mk_fixed(0, 16'h0003, nx(50, 320), nx(115, 200), 6,
                                ACT_UP, 5'h11));
        rows.push_back(mk(0, 16'h0004, nx(50, 320), nx(185, 200), 7));
        rows.push_back(mk(0, 16'h0005, nx(15, 320), nx(150, 200), 8));
        rows.push_back(mk(0, 16'h0006, nx(85, 320), nx(150, 200), 9));
        rows.push_back(mk(0, 16'h0003, nx(80, 320), nx(120, 200), 10));
        rows.push_back(mk(0, 16'h0003, nx(20, 320), nx(120, 200), 11));
        rows.push_back(mk(0, 16'h0003, nx(80, 320), nx(180, 200), 12));
        rows.push_back(mk(0, 16'h0003, nx(20, 320), nx(180, 200), 13));
        rows.push_back(mk(0, 16'h0003, nx(50, 320), nx(150, 200), 14));
        rows.push_back(mk(0, 16'h0003, nx(89, 320), nx(150, 200), 15));
        rows.push_back(mk(0, 16'h0003, nx(10, 320), nx(110, 200), 16));
        rows.push_back(mk(1, 16'h0003, 0, 0, 0));
        rows.push_back(mk(1, 16'h0003, 0, 0, 0));
        rows.push_back(mk_fixed(1, 16'h1234, 0, 0, 0, ACT_NONE, 5'h0E));
        rows.push_back(mk(0, 16'h0008, 17'h15555, 17'h0AAAA, 32'h80000000));
        send_rows();
        drain();

        write_reg(REG_RENDER, 12'd1);
        write_reg(REG_VP_W, 12'd4095);
        write_reg(REG_VP_H, 12'd4095);
        write_reg(REG_SCR_W, 12'd4095);
        write_reg(REG_SCR_H, 12'd4095);
        for (int i = 0; i < 150; i++) rows.push_back(random_touch(7));
        send_rows();
        drain();

        write_reg(REG_VP_W, 12'd1);
        write_reg(REG_VP_H, 12'd1);
        write_reg(REG_SCR_W, 12'd128);
        write_reg(REG_SCR_H, 12'd128);
        write_reg(REG_RENDER, 12'd0);
        for (int i = 0; i < 60; i++) rows.push_back(random_touch(7));
        send_rows();
        drain();

        write_reg(REG_VP_W, 12'd320);
        write_reg(REG_VP_H, 12'd200);
        write_reg(REG_SCR_W, 12'd320);
        write_reg(REG_SCR_H, 12'd200);
        write_reg(REG_RENDER, 12'd1);
        for (int i = 0; i < 250; i++) rows.push_back(random_touch(9));
        send_rows();
        drain();

        write_reg(REG_VP_W, 12'd640);
        write_reg(REG_VP_H, 12'd480);
        write_reg(REG_SCR_W, 12'd640);
        write_reg(REG_SCR_H, 12'd480);
        for (int i = 0; i < 140; i++) rows.push_back(random_touch(6));
        send_rows();
        drain();
        done = 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            rx_count <= rx_count + 1;
            case ($urandom_range(0, 2))
                0: m_axis_tready <= (rx_count % 7 < 4) ? 1'b1 : ($urandom_range(0, 1) == 1);
                default: m_axis_tready <= 1'b1;
            endcase
        end
        if (m_axis_tvalid && m_axis_tready)
        begin
            dpad_result_t got, want;
            got = m_axis_tdata[10:0];
            if (pending_results.size() == 0)
            begin
                report("unexpected item", 32'(got), 0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.action != want.action) report("action", got.action, want.action);
                if (got.held != want.held) report("held_events", got.held, want.held);
                if (got.hit != want.hit) report("pad_hit", got.hit, want.hit);
                if (got.unknown != want.unknown)
                    report("release_unknown", got.unknown, want.unknown);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || wr_en)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        wait (done || idle_cycles >= STALL_LIMIT);
        if (done)
        begin
            if (errors == 0 && pending_results.size() == 0)
                $display("RESULT: OK");
            else
                $display("RESULT: ERROR");
        end
        else
        begin
            $display("watchdog expired at %0t", $realtime);
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
